[hw/rtl/hbo_pkg.sv]
// ============================================================================
// hbo_pkg: shared types and constants for the heightfield box overlap core
// Holds sequencer states, register indexes, opcodes and divider width/types.
// ============================================================================
package hbo_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z    = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE   = 3'd2;
    localparam logic [2:0] REG_VOXEL_EDGE  = 3'd3;
    localparam logic [2:0] REG_GRID_POINTS = 3'd4;

    // Item opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Dividend width for the floor divider (signed, 34 bits covers a 33-bit
    // difference of two Q16.16 values).
    localparam int DIV_W = 34;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COVER,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CELL_INIT,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_RD_TAKE,
        ST_TOP_START,
        ST_TOP_WAIT,
        ST_TOP_CMP,
        ST_DONE
    } state_t;

    // Request to the shared floor divider.
    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [30:0]             divisor;
    } div_req_t;

    // Reply from the shared floor divider.
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hw/rtl/hbo_floor_div.sv]
// ============================================================================
// hbo_floor_div: iterative signed floor divider
// Restoring division of the magnitude, one quotient bit per cycle, with a
// floor correction for negative dividends that leave a remainder.
// ============================================================================
module hbo_floor_div (
    input  logic             clk,
    input  logic             rst_n,
    input  hbo_pkg::div_req_t req,
    output hbo_pkg::div_rsp_t rsp
);

    localparam int W  = hbo_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  mag_reg, mag_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [31:0]   rem_reg, rem_next;
    logic [30:0]   den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [31:0]   shifted;
    logic [31:0]   diff;
    logic          fit;
    logic [W-1:0]  neg_q;

    // One restoring step per cycle on the magnitude.
    always_comb
    begin
        shifted   = {rem_reg[30:0], mag_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        fit       = (shifted >= {1'b0, den_reg});
        mag_next  = mag_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            neg_next  = req.dividend[W-1];
            mag_next  = req.dividend[W-1] ? W'(-req.dividend) : W'(req.dividend);
            den_next  = (req.divisor == 31'd0) ? 31'd1 : req.divisor;
            rem_next  = 32'd0;
            quo_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fit ? diff : shifted;
            quo_next = {quo_reg[W-2:0], fit};
            mag_next = {mag_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Floor: a negative quotient with a remainder steps down by one.
    always_comb
    begin
        neg_q        = W'(-quo_reg) - ((rem_reg != 32'd0) ? W'(1) : W'(0));
        rsp.busy     = busy_reg;
        rsp.done     = done_reg;
        rsp.quotient = neg_reg ? neg_q : quo_reg;
    end

endmodule

[hw/rtl/heightfield_box_overlap_core.sv]
// ============================================================================
// heightfield_box_overlap_core: terrain heightfield versus box overlap test
// Stores a square grid of heights and tests box footprints against it.
// ============================================================================
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | op, sample_index, ... box_max_z
//  out     | out       | out_valid/out_stall| covered, hit
//
//  A load goes straight to the done state, and a query that is not covered ends
//  after the cover check. A covered query runs the cover check and four floor
//  divisions, then for each visited cell four corner reads, one floor division and
//  a compare. The shared serial divider works in 34 steps.
//  Reset clears control and config registers; heights are undefined until loaded.
//  The result waits in an output register while out_stall is high.
// ============================================================================
module heightfield_box_overlap_core #(
    parameter int GRID_SIDE = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [11:0]         sample_index,
    input  logic signed [31:0]  sample_height,
    input  logic signed [31:0]  box_min_x,
    input  logic signed [31:0]  box_min_y,
    input  logic signed [31:0]  box_min_z,
    input  logic signed [31:0]  box_max_x,
    input  logic signed [31:0]  box_max_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                covered,
    output logic                hit
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(GRID_SIDE + 1);
    localparam int W     = hbo_pkg::DIV_W;
    localparam int PW    = SW + 31;
    localparam int XW    = SW + 33;

    // Configuration registers.
    logic signed [31:0] origin_x_reg, origin_z_reg;
    logic [30:0]        cell_size_reg, voxel_edge_reg;
    logic [6:0]         grid_points_reg;

    // Sequencer and item registers.
    hbo_pkg::state_t state_reg, state_next;
    logic signed [31:0] bx0_reg, by0_reg, bz0_reg, bx1_reg, bz1_reg;
    logic               out_valid_reg, covered_reg, hit_reg;
    logic signed [W-1:0] ix0_reg, iz0_reg, ix1_reg, iz1_reg;
    logic signed [W-1:0] ix_reg, iz_reg;
    logic [1:0]         dsel_reg, corner_reg;
    logic signed [31:0] hmax_reg;
    logic signed [W-1:0] top_reg;

    logic signed [W-1:0] cell_s, edge_s, n_s, ox_s, oz_s;
    logic [SW-1:0]      n_eff;
    logic               cov_c;
    hbo_pkg::div_req_t  dreq;
    hbo_pkg::div_rsp_t  drsp;
    logic signed [W-1:0] cx, cz, ccx, ccz;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] mem [DEPTH];
    logic               in_xfer, out_xfer;
    logic [PW-1:0]      span_w;
    logic signed [XW-1:0] cell_x, span_x, ox_x, oz_x;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != hbo_pkg::ST_IDLE) || out_valid_reg;
    assign cfg_ready = (state_reg == hbo_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign covered   = covered_reg;
    assign hit       = hit_reg;

    // Effective grid parameters.
    always_comb
    begin
        if (grid_points_reg < 7'd2)
            n_eff = SW'(2);
        else if (32'(grid_points_reg) > GRID_SIDE)
            n_eff = SW'(GRID_SIDE);
        else
            n_eff = SW'(grid_points_reg);
        cell_s = (cell_size_reg == 31'd0) ? W'(1) : W'(cell_size_reg);
        edge_s = (voxel_edge_reg == 31'd0) ? W'(1) : W'(voxel_edge_reg);
        n_s    = W'(n_eff);
        ox_s   = W'(origin_x_reg);
        oz_s   = W'(origin_z_reg);
    end

    // Span (n - 1) * cell: a small multiplier of the point count by the 31-bit
    // spacing. The cover check runs wide enough to hold origin plus span.
    assign span_w = PW'(n_eff - SW'(1)) * PW'(cell_s[30:0]);
    assign span_x = XW'(span_w);
    assign cell_x = XW'(cell_s);
    assign ox_x   = XW'(origin_x_reg);
    assign oz_x   = XW'(origin_z_reg);

    assign cov_c = (XW'(bx0_reg) - cell_x >= ox_x) && (XW'(bz0_reg) - cell_x >= oz_x)
                && (XW'(bx1_reg) + cell_x <= ox_x + span_x)
                && (XW'(bz1_reg) + cell_x <= oz_x + span_x);

    // Corner address, clamped to the grid.
    always_comb
    begin
        cx  = ix_reg + W'(corner_reg[0]);
        cz  = iz_reg + W'(corner_reg[1]);
        ccx = (cx < 0) ? W'(0) : ((cx > n_s - W'(1)) ? n_s - W'(1) : cx);
        ccz = (cz < 0) ? W'(0) : ((cz > n_s - W'(1)) ? n_s - W'(1) : cz);
        rd_addr = AW'(ccz * n_s + ccx);
    end

    // Divider requests: four floor divisions for the range, one per cell.
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.divisor  = cell_s[30:0];
        dreq.dividend = W'(bx0_reg) - ox_s;
        case (dsel_reg)
            2'd0: dreq.dividend = W'(bx0_reg) - ox_s;
            2'd1: dreq.dividend = W'(bz0_reg) - oz_s;
            2'd2: dreq.dividend = W'(bx1_reg) - ox_s;
            default: dreq.dividend = W'(bz1_reg) - oz_s;
        endcase
        if (state_reg == hbo_pkg::ST_DIV_START)
            dreq.start = 1'b1;
        if (state_reg == hbo_pkg::ST_TOP_START)
        begin
            dreq.start    = 1'b1;
            dreq.divisor  = edge_s[30:0];
            dreq.dividend = W'(hmax_reg);
        end
    end

    hbo_floor_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Height store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_xfer && op == hbo_pkg::OP_LOAD && 32'(sample_index) < DEPTH)
            mem[AW'(sample_index)] <= sample_height;
        rd_data_reg <= mem[rd_addr];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbo_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = (op == hbo_pkg::OP_QUERY) ? hbo_pkg::ST_COVER
                                                          : hbo_pkg::ST_DONE;
            hbo_pkg::ST_COVER:
                state_next = cov_c ? hbo_pkg::ST_DIV_START : hbo_pkg::ST_DONE;
            hbo_pkg::ST_DIV_START: state_next = hbo_pkg::ST_DIV_WAIT;
            hbo_pkg::ST_DIV_WAIT:
                if (drsp.done)
                    state_next = (dsel_reg == 2'd3) ? hbo_pkg::ST_CELL_INIT
                                                    : hbo_pkg::ST_DIV_START;
            hbo_pkg::ST_CELL_INIT:
                state_next = (ix0_reg > ix1_reg || iz0_reg > iz1_reg) ? hbo_pkg::ST_DONE
                                                                      : hbo_pkg::ST_RD_ISSUE;
            hbo_pkg::ST_RD_ISSUE: state_next = hbo_pkg::ST_RD_WAIT;
            hbo_pkg::ST_RD_WAIT:  state_next = hbo_pkg::ST_RD_TAKE;
            hbo_pkg::ST_RD_TAKE:
                state_next = (corner_reg == 2'd3) ? hbo_pkg::ST_TOP_START
                                                  : hbo_pkg::ST_RD_ISSUE;
            hbo_pkg::ST_TOP_START: state_next = hbo_pkg::ST_TOP_WAIT;
            hbo_pkg::ST_TOP_WAIT:
                if (drsp.done)
                    state_next = hbo_pkg::ST_TOP_CMP;
            hbo_pkg::ST_TOP_CMP:
                if (top_reg > W'(by0_reg))
                    state_next = hbo_pkg::ST_DONE;
                else if (ix_reg == ix1_reg && iz_reg == iz1_reg)
                    state_next = hbo_pkg::ST_DONE;
                else
                    state_next = hbo_pkg::ST_RD_ISSUE;
            hbo_pkg::ST_DONE: state_next = hbo_pkg::ST_IDLE;
            default: state_next = hbo_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hbo_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            origin_x_reg    <= '0;
            origin_z_reg    <= '0;
            cell_size_reg   <= 31'd65536;
            voxel_edge_reg  <= 31'd65536;
            grid_points_reg <= 7'd64;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hbo_pkg::ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hbo_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                    hbo_pkg::REG_ORIGIN_Z:    origin_z_reg    <= cfg_data;
                    hbo_pkg::REG_CELL_SIZE:   cell_size_reg   <= cfg_data[30:0];
                    hbo_pkg::REG_VOXEL_EDGE:  voxel_edge_reg  <= cfg_data[30:0];
                    hbo_pkg::REG_GRID_POINTS: grid_points_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hbo_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    bx0_reg     <= box_min_x;
                    by0_reg     <= box_min_y;
                    bz0_reg     <= box_min_z;
                    bx1_reg     <= box_max_x;
                    bz1_reg     <= box_max_z;
                    covered_reg <= 1'b1;
                    hit_reg     <= 1'b0;
                    dsel_reg    <= 2'd0;
                end
            hbo_pkg::ST_COVER:
                covered_reg <= cov_c;
            hbo_pkg::ST_DIV_WAIT:
                if (drsp.done)
                begin
                    case (dsel_reg)
                        2'd0: ix0_reg <= drsp.quotient;
                        2'd1: iz0_reg <= drsp.quotient;
                        2'd2: ix1_reg <= drsp.quotient;
                        default: iz1_reg <= drsp.quotient;
                    endcase
                    dsel_reg <= dsel_reg + 2'd1;
                end
            hbo_pkg::ST_CELL_INIT:
            begin
                ix_reg     <= ix0_reg;
                iz_reg     <= iz0_reg;
                corner_reg <= 2'd0;
            end
            hbo_pkg::ST_RD_TAKE:
            begin
                if (corner_reg == 2'd0 || rd_data_reg > hmax_reg)
                    hmax_reg <= rd_data_reg;
                corner_reg <= corner_reg + 2'd1;
            end
            hbo_pkg::ST_TOP_WAIT:
                if (drsp.done)
                    top_reg <= W'(drsp.quotient * edge_s) + edge_s;
            hbo_pkg::ST_TOP_CMP:
            begin
                if (top_reg > W'(by0_reg))
                    hit_reg <= 1'b1;
                if (ix_reg == ix1_reg)
                begin
                    ix_reg <= ix0_reg;
                    iz_reg <= iz_reg + W'(1);
                end
                else
                    ix_reg <= ix_reg + W'(1);
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // No new item while a result is still waiting.
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("input accepted while result pending");

    // A finished sequence always raises the result.
    a_done_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hbo_pkg::ST_DONE |=> out_valid_reg)
        else $error("result not raised after done");

    // A hit implies the box was covered.
    a_hit_needs_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> covered_reg)
        else $error("hit reported without coverage");
`endif

endmodule
